/* rtl/gpst_pkg.sv */
// Shared types and constants for the generational peer slot table.
// Used by the slot cell, the event cell, the top level and the checker.
package gpst_pkg;

    localparam int PEER_SLOTS_DEF  = 8;
    localparam int EVENT_DEPTH_DEF = 16;

    localparam int ACCOUNT_W  = 64;
    localparam int GEN_W      = 32;
    localparam int HSLOT_W    = 8;
    localparam int ACTION_W   = 3;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 3;
    localparam int KIND_W     = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CONNECT         = 3'd0,
        ACT_SESSION_REQUEST = 3'd1,
        ACT_SESSION_FAILED  = 3'd2,
        ACT_RESOLVE         = 3'd3,
        ACT_POP_EVENT       = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_REFUSED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NO_EVENT  = 3'd4,
        ST_IGNORED   = 3'd5
    } status_t;

    typedef enum logic [KIND_W-1:0] {
        EV_NONE         = 2'd0,
        EV_CONNECTED    = 2'd1,
        EV_DISCONNECTED = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_SCAN   = 2'd1,
        FSM_FINISH = 2'd2
    } state_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic             free;
        logic [GEN_W-1:0] hit_gen;
        logic [GEN_W-1:0] free_gen;
    } probe_t;

    typedef struct packed {
        logic                 by_index;
        logic [ACCOUNT_W-1:0] account;
        logic [HSLOT_W-1:0]   hslot;
        logic [GEN_W-1:0]     hgen;
        logic                 wr_alloc;
        logic                 wr_free;
    } slot_cmd_t;

endpackage

/* rtl/gpst_slot_cell.sv */
// One peer slot: live flag, account and generation, plus one stage of the probe chain.
// Depends on gpst_pkg for the probe and command structs.
module gpst_slot_cell
    import gpst_pkg::*;
#(
    parameter int SLOT_W = 3,
    parameter int IDX    = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  slot_cmd_t         cmd,
    input  logic [SLOT_W-1:0] wr_idx,
    input  probe_t            probe_in,
    input  logic [SLOT_W-1:0] hit_idx_in,
    input  logic [SLOT_W-1:0] free_idx_in,
    output probe_t            probe_out,
    output logic [SLOT_W-1:0] hit_idx_out,
    output logic [SLOT_W-1:0] free_idx_out
);

    localparam logic [SLOT_W-1:0]  MY_IDX   = SLOT_W'(IDX);
    localparam logic [HSLOT_W-1:0] MY_HSLOT = HSLOT_W'(IDX);

    logic                 live_reg, live_next;
    logic [GEN_W-1:0]     gen_reg, gen_next;
    logic [ACCOUNT_W-1:0] account_reg, account_next;
    probe_t               probe_reg, probe_next;
    logic [SLOT_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [SLOT_W-1:0]    free_idx_reg, free_idx_next;
    logic                 match;
    logic                 sel;

    always_comb
    begin
        if (cmd.by_index)
        begin
            match = live_reg && (cmd.hslot == MY_HSLOT) && (gen_reg == cmd.hgen);
        end
        else
        begin
            match = live_reg && (account_reg == cmd.account);
        end
    end

    always_comb
    begin
        probe_next    = probe_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        if (probe_in.valid && !probe_in.hit && match)
        begin
            probe_next.hit     = 1'b1;
            probe_next.hit_gen = gen_reg;
            hit_idx_next       = MY_IDX;
        end
        if (probe_in.valid && !probe_in.free && !live_reg)
        begin
            probe_next.free     = 1'b1;
            probe_next.free_gen = gen_reg;
            free_idx_next       = MY_IDX;
        end
    end

    assign sel = (wr_idx == MY_IDX);

    always_comb
    begin
        live_next    = live_reg;
        gen_next     = gen_reg;
        account_next = account_reg;
        priority if (sel && cmd.wr_alloc)
        begin
            live_next    = 1'b1;
            gen_next     = gen_reg + GEN_W'(1);
            account_next = cmd.account;
        end
        else if (sel && cmd.wr_free)
        begin
            live_next    = 1'b0;
            account_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= 1'b0;
            gen_reg   <= '0;
            probe_reg <= '0;
        end
        else
        begin
            live_reg  <= live_next;
            gen_reg   <= gen_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        account_reg  <= account_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign probe_out    = probe_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

/* rtl/gpst_event_cell.sv */
// One entry of the shifting event queue; a pop moves every entry one place toward the head.
// Depends on gpst_pkg for field widths.
module gpst_event_cell
    import gpst_pkg::*;
#(
    parameter int SLOT_W   = 3,
    parameter int EV_IDX_W = 4,
    parameter int IDX      = 0
)
(
    input  logic                clk,
    input  logic                push,
    input  logic                pop,
    input  logic [EV_IDX_W-1:0] push_idx,
    input  logic [KIND_W-1:0]   push_kind,
    input  logic [SLOT_W-1:0]   push_slot,
    input  logic [GEN_W-1:0]    push_gen,
    input  logic [KIND_W-1:0]   next_kind,
    input  logic [SLOT_W-1:0]   next_slot,
    input  logic [GEN_W-1:0]    next_gen,
    output logic [KIND_W-1:0]   entry_kind,
    output logic [SLOT_W-1:0]   entry_slot,
    output logic [GEN_W-1:0]    entry_gen
);

    localparam logic [EV_IDX_W-1:0] MY_IDX = EV_IDX_W'(IDX);

    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [GEN_W-1:0]  gen_reg, gen_next;

    always_comb
    begin
        kind_next = kind_reg;
        slot_next = slot_reg;
        gen_next  = gen_reg;
        priority if (pop)
        begin
            kind_next = next_kind;
            slot_next = next_slot;
            gen_next  = next_gen;
        end
        else if (push && (push_idx == MY_IDX))
        begin
            kind_next = push_kind;
            slot_next = push_slot;
            gen_next  = push_gen;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        slot_reg <= slot_next;
        gen_reg  <= gen_next;
    end

    assign entry_kind = kind_reg;
    assign entry_slot = slot_reg;
    assign entry_gen  = gen_reg;

endmodule

/* rtl/generational_peer_slot_table.sv */
// Top level of the generational peer slot table: control, slot cell row and event queue.
// Depends on gpst_pkg, gpst_slot_cell and gpst_event_cell.
//
// A word is taken only in the idle state: the lookup probe is launched from a register and
// walks the row of slot cells one cell per cycle, then the decision is registered and the
// output register is loaded. The next word is accepted once the table is back in idle, so
// the table takes no new word before the last one is loaded into the output register. A
// finished result waits in the output register while a new word is accepted; the next
// result waits until it is taken, and the input stalls meanwhile. The event queue shifts
// on every pop and drops events pushed while it is full.
module generational_peer_slot_table
    import gpst_pkg::*;
#(
    parameter int PEER_SLOTS  = PEER_SLOTS_DEF,
    parameter int EVENT_DEPTH = EVENT_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [ACTION_W-1:0]   action,
    input  logic [ACCOUNT_W-1:0]  account,
    input  logic [HSLOT_W-1:0]    handle_slot,
    input  logic [GEN_W-1:0]      handle_generation,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [SLOT_OUT_W-1:0] slot,
    output logic [GEN_W-1:0]      generation,
    output logic [KIND_W-1:0]     event_kind,
    output logic                  event_timeout
);

    localparam int SLOT_W   = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int EV_IDX_W = $clog2(EVENT_DEPTH);
    localparam int CNT_W    = $clog2(EVENT_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(EVENT_DEPTH);

    state_t               state_reg, state_next;
    logic                 accepting_reg;
    logic                 launch_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ACTION_W-1:0]  action_reg;
    logic [ACCOUNT_W-1:0] account_reg;
    logic [HSLOT_W-1:0]   hslot_reg;
    logic [GEN_W-1:0]     hgen_reg;

    logic [STATUS_W-1:0]  pend_status_reg;
    logic [SLOT_W-1:0]    pend_slot_reg;
    logic [GEN_W-1:0]     pend_gen_reg;
    logic [KIND_W-1:0]    pend_kind_reg;
    logic                 pend_tmo_reg;

    logic                  result_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;
    logic [GEN_W-1:0]      gen_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic                  tmo_reg;

    probe_t            probe_chain    [PEER_SLOTS+1];
    logic [SLOT_W-1:0] hit_idx_chain  [PEER_SLOTS+1];
    logic [SLOT_W-1:0] free_idx_chain [PEER_SLOTS+1];
    probe_t            tail;

    logic [KIND_W-1:0] ev_kind_chain [EVENT_DEPTH+1];
    logic [SLOT_W-1:0] ev_slot_chain [EVENT_DEPTH+1];
    logic [GEN_W-1:0]  ev_gen_chain  [EVENT_DEPTH+1];

    slot_cmd_t         cmd;
    logic [SLOT_W-1:0] wr_idx;
    logic              accept;
    logic              decide;
    logic              deliver;
    logic              do_alloc;
    logic              do_free;
    logic              want_push;
    logic              push_en;
    logic              do_pop;
    logic [KIND_W-1:0] push_kind;
    logic [SLOT_W-1:0] push_slot;
    logic [GEN_W-1:0]  push_gen;

    logic [STATUS_W-1:0] dec_status;
    logic [SLOT_W-1:0]   dec_slot;
    logic [GEN_W-1:0]    dec_gen;
    logic [KIND_W-1:0]   dec_kind;
    logic                dec_tmo;
    logic                zero_account;

    assign accept     = (state_reg == FSM_IDLE) && item_valid;
    assign item_stall = (state_reg != FSM_IDLE);
    assign tail       = probe_chain[PEER_SLOTS];
    assign decide     = (state_reg == FSM_SCAN) && tail.valid;
    assign deliver    = (state_reg == FSM_FINISH) && !(result_valid_reg && result_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_FINISH:
            begin
                if (!(result_valid_reg && result_stall))
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign zero_account = (action_reg <= ACT_SESSION_FAILED) && (account_reg == '0);

    always_comb
    begin
        dec_status = ST_IGNORED;
        dec_slot   = '0;
        dec_gen    = '0;
        dec_kind   = EV_NONE;
        dec_tmo    = 1'b0;
        do_alloc   = 1'b0;
        do_free    = 1'b0;
        want_push  = 1'b0;
        do_pop     = 1'b0;
        wr_idx     = '0;
        push_kind  = EV_NONE;
        push_slot  = '0;
        push_gen   = '0;
        if (!zero_account)
        begin
            case (action_reg)
                ACT_CONNECT, ACT_SESSION_REQUEST:
                begin
                    priority if (tail.hit)
                    begin
                        dec_status = ST_OK;
                        dec_slot   = hit_idx_chain[PEER_SLOTS];
                        dec_gen    = tail.hit_gen;
                    end
                    else if ((action_reg == ACT_SESSION_REQUEST) && !accepting_reg)
                    begin
                        dec_status = ST_REFUSED;
                    end
                    else if (tail.free)
                    begin
                        dec_status = ST_OK;
                        dec_slot   = free_idx_chain[PEER_SLOTS];
                        dec_gen    = tail.free_gen + GEN_W'(1);
                        do_alloc   = 1'b1;
                        wr_idx     = free_idx_chain[PEER_SLOTS];
                        want_push  = 1'b1;
                        push_kind  = EV_CONNECTED;
                        push_slot  = free_idx_chain[PEER_SLOTS];
                        push_gen   = tail.free_gen + GEN_W'(1);
                    end
                    else
                    begin
                        dec_status = ST_FULL;
                    end
                end
                ACT_SESSION_FAILED:
                begin
                    if (tail.hit)
                    begin
                        dec_status = ST_OK;
                        dec_slot   = hit_idx_chain[PEER_SLOTS];
                        dec_gen    = tail.hit_gen;
                        do_free    = 1'b1;
                        wr_idx     = hit_idx_chain[PEER_SLOTS];
                        want_push  = 1'b1;
                        push_kind  = EV_DISCONNECTED;
                        push_slot  = hit_idx_chain[PEER_SLOTS];
                        push_gen   = tail.hit_gen;
                    end
                    else
                    begin
                        dec_status = ST_NOT_FOUND;
                    end
                end
                ACT_RESOLVE:
                begin
                    if (tail.hit)
                    begin
                        dec_status = ST_OK;
                        dec_slot   = hit_idx_chain[PEER_SLOTS];
                        dec_gen    = hgen_reg;
                    end
                    else
                    begin
                        dec_status = ST_NOT_FOUND;
                    end
                end
                ACT_POP_EVENT:
                begin
                    if (count_reg == '0)
                    begin
                        dec_status = ST_NO_EVENT;
                    end
                    else
                    begin
                        dec_status = ST_OK;
                        dec_slot   = ev_slot_chain[0];
                        dec_gen    = ev_gen_chain[0];
                        dec_kind   = ev_kind_chain[0];
                        dec_tmo    = (ev_kind_chain[0] == EV_DISCONNECTED);
                        do_pop     = 1'b1;
                    end
                end
                default:
                begin
                    dec_status = ST_IGNORED;
                end
            endcase
        end
    end

    assign push_en = decide && want_push && (count_reg != CNT_FULL);

    always_comb
    begin
        count_next = count_reg;
        priority if (decide && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (push_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        cmd.by_index = (action_reg == ACT_RESOLVE);
        cmd.account  = account_reg;
        cmd.hslot    = hslot_reg;
        cmd.hgen     = hgen_reg;
        cmd.wr_alloc = decide && do_alloc;
        cmd.wr_free  = decide && do_free;
    end

    always_comb
    begin
        probe_chain[0]          = '0;
        probe_chain[0].valid    = launch_reg;
        hit_idx_chain[0]        = '0;
        free_idx_chain[0]       = '0;
    end

    for (genvar i = 0; i < PEER_SLOTS; i++)
    begin : g_slot
        gpst_slot_cell #(
            .SLOT_W (SLOT_W),
            .IDX    (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .wr_idx       (wr_idx),
            .probe_in     (probe_chain[i]),
            .hit_idx_in   (hit_idx_chain[i]),
            .free_idx_in  (free_idx_chain[i]),
            .probe_out    (probe_chain[i+1]),
            .hit_idx_out  (hit_idx_chain[i+1]),
            .free_idx_out (free_idx_chain[i+1])
        );
    end

    assign ev_kind_chain[EVENT_DEPTH] = EV_NONE;
    assign ev_slot_chain[EVENT_DEPTH] = '0;
    assign ev_gen_chain[EVENT_DEPTH]  = '0;

    for (genvar k = 0; k < EVENT_DEPTH; k++)
    begin : g_event
        gpst_event_cell #(
            .SLOT_W   (SLOT_W),
            .EV_IDX_W (EV_IDX_W),
            .IDX      (k)
        ) u_entry (
            .clk        (clk),
            .push       (push_en),
            .pop        (decide && do_pop),
            .push_idx   (count_reg[EV_IDX_W-1:0]),
            .push_kind  (push_kind),
            .push_slot  (push_slot),
            .push_gen   (push_gen),
            .next_kind  (ev_kind_chain[k+1]),
            .next_slot  (ev_slot_chain[k+1]),
            .next_gen   (ev_gen_chain[k+1]),
            .entry_kind (ev_kind_chain[k]),
            .entry_slot (ev_slot_chain[k]),
            .entry_gen  (ev_gen_chain[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= FSM_IDLE;
            accepting_reg    <= 1'b0;
            launch_reg       <= 1'b0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= accept;
            count_reg  <= count_next;
            if (cfg_write)
            begin
                accepting_reg <= cfg_data;
            end
            if (deliver)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg  <= action;
            account_reg <= account;
            hslot_reg   <= handle_slot;
            hgen_reg    <= handle_generation;
        end
        if (decide)
        begin
            pend_status_reg <= dec_status;
            pend_slot_reg   <= dec_slot;
            pend_gen_reg    <= dec_gen;
            pend_kind_reg   <= dec_kind;
            pend_tmo_reg    <= dec_tmo;
        end
        if (deliver)
        begin
            status_reg <= pend_status_reg;
            slot_reg   <= SLOT_OUT_W'(pend_slot_reg);
            gen_reg    <= pend_gen_reg;
            kind_reg   <= pend_kind_reg;
            tmo_reg    <= pend_tmo_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign slot          = slot_reg;
    assign generation    = gen_reg;
    assign event_kind    = kind_reg;
    assign event_timeout = tmo_reg;

endmodule

/* rtl/gpst_checker.sv */
// Port-level checks for the generational peer slot table, bound to the top level.
// Depends on gpst_pkg and generational_peer_slot_table.
module gpst_assertions
    import gpst_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_valid,
    input logic                  item_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input logic [STATUS_W-1:0]   status,
    input logic [SLOT_OUT_W-1:0] slot,
    input logic [GEN_W-1:0]      generation,
    input logic [KIND_W-1:0]     event_kind,
    input logic                  event_timeout
);

    // An accepted word occupies the table until its result is loaded into the output register.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input taken again right after a word was accepted");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status) && $stable(slot)
            && $stable(generation) && $stable(event_kind) && $stable(event_timeout))
        else $error("stalled result word changed");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_OK) |-> (slot == '0) && (generation == '0)
            && (event_kind == EV_NONE) && !event_timeout)
        else $error("failed result carries slot or event data");

    a_event_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (event_kind != EV_NONE) |->
            (status == ST_OK) && (event_timeout == (event_kind == EV_DISCONNECTED)))
        else $error("popped event fields disagree");

endmodule

bind generational_peer_slot_table gpst_assertions u_gpst_assertions (.*);
